@@ sv/jed_pkg.sv @@
// Package for the JSON string escape decoder: decode modes, error codes,
// character constants, result type and the hex digit decoder.
// No dependencies.
package jed_pkg;

  localparam int BYTE_W = 8;
  localparam int ERR_W  = 2;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef enum logic [2:0] {
    MODE_NORMAL  = 3'd0,
    MODE_ESCAPE  = 3'd1,
    MODE_HEX1    = 3'd2,
    MODE_HEX2    = 3'd3,
    MODE_HEX3    = 3'd4,
    MODE_HEX4    = 3'd5,
    MODE_DISCARD = 3'd6
  } mode_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE     = 2'd0,
    ERR_LETTER   = 2'd1,
    ERR_UNICODE  = 2'd2,
    ERR_TRAILING = 2'd3
  } err_t;

  localparam byte_t CH_QUOTE = 8'h22;
  localparam byte_t CH_BSLASH = 8'h5C;
  localparam byte_t CH_SLASH = 8'h2F;
  localparam byte_t CH_B = 8'h62;
  localparam byte_t CH_F = 8'h66;
  localparam byte_t CH_N = 8'h6E;
  localparam byte_t CH_R = 8'h72;
  localparam byte_t CH_T = 8'h74;
  localparam byte_t CH_U = 8'h75;

  localparam byte_t CTL_BS = 8'h08;
  localparam byte_t CTL_FF = 8'h0C;
  localparam byte_t CTL_LF = 8'h0A;
  localparam byte_t CTL_CR = 8'h0D;
  localparam byte_t CTL_HT = 8'h09;

  typedef struct packed {
    byte_t             out_byte;
    err_t              error_code;
    logic              last;
  } res_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_value(input byte_t c);
    hex_t h;
    h.ok    = 1'b1;
    h.value = 4'd0;
    case (c) inside
      [8'h30:8'h39]: h.value = 4'(c - 8'h30);
      [8'h61:8'h66]: h.value = 4'(c - 8'h61 + 8'd10);
      [8'h41:8'h46]: h.value = 4'(c - 8'h41 + 8'd10);
      default:       h.ok = 1'b0;
    endcase
    return h;
  endfunction

endpackage

@@ sv/jed_if.sv @@
// Valid/ready channel interfaces for the escape decoder's input and results.
// Depends on jed_pkg for field widths.
interface jed_in_if;
  logic                       valid;
  logic                       ready;
  logic [jed_pkg::BYTE_W-1:0] in_byte;
  logic                       end_of_string;

  modport source (output valid, output in_byte, output end_of_string, input ready);
  modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface jed_out_if;
  logic                       valid;
  logic                       ready;
  logic [jed_pkg::BYTE_W-1:0] out_byte;
  logic [jed_pkg::ERR_W-1:0]  error_code;
  logic                       last;

  modport source (output valid, output out_byte, output error_code, output last,
                  input ready);
  modport sink   (input valid, input out_byte, input error_code, input last,
                  output ready);
endinterface

@@ sv/jed_step.sv @@
// Per-byte decode step: next mode, next hex value and the optional result.
// Depends on jed_pkg.
module jed_step (
  input  jed_pkg::mode_t mode,
  input  jed_pkg::byte_t hex_acc,
  input  jed_pkg::byte_t in_byte,
  input  logic           end_of_string,
  output jed_pkg::mode_t mode_nxt,
  output jed_pkg::byte_t hex_acc_nxt,
  output logic           emit,
  output jed_pkg::res_t  res
);
  import jed_pkg::*;

  hex_t  hex;
  err_t  fail_err;
  logic  fail;
  byte_t acc_shift;

  assign hex       = hex_value(in_byte);
  assign acc_shift = {hex_acc[3:0], hex.value};

  always_comb begin
    mode_nxt    = mode;
    hex_acc_nxt = hex_acc;
    emit        = 1'b0;
    res         = '{out_byte: '0, error_code: ERR_NONE, last: end_of_string};
    fail        = 1'b0;
    fail_err    = ERR_NONE;
    case (mode)
      MODE_DISCARD: begin
        if (end_of_string) begin
          mode_nxt = MODE_NORMAL;
        end
      end
      MODE_ESCAPE: begin
        emit     = 1'b1;
        mode_nxt = MODE_NORMAL;
        case (in_byte)
          CH_QUOTE:  res.out_byte = CH_QUOTE;
          CH_BSLASH: res.out_byte = CH_BSLASH;
          CH_SLASH:  res.out_byte = CH_SLASH;
          CH_B:      res.out_byte = CTL_BS;
          CH_F:      res.out_byte = CTL_FF;
          CH_N:      res.out_byte = CTL_LF;
          CH_R:      res.out_byte = CTL_CR;
          CH_T:      res.out_byte = CTL_HT;
          CH_U: begin
            if (end_of_string) begin
              fail     = 1'b1;
              fail_err = ERR_UNICODE;
            end else begin
              emit        = 1'b0;
              mode_nxt    = MODE_HEX1;
              hex_acc_nxt = '0;
            end
          end
          default: begin
            fail     = 1'b1;
            fail_err = ERR_LETTER;
          end
        endcase
      end
      MODE_HEX1, MODE_HEX2, MODE_HEX3, MODE_HEX4: begin
        if (!hex.ok) begin
          fail     = 1'b1;
          fail_err = ERR_UNICODE;
        end else begin
          hex_acc_nxt = acc_shift;
          if (mode == MODE_HEX4) begin
            emit         = 1'b1;
            mode_nxt     = MODE_NORMAL;
            res.out_byte = acc_shift;
          end else if (end_of_string) begin
            fail     = 1'b1;
            fail_err = ERR_UNICODE;
          end else begin
            mode_nxt = mode_t'(mode + 3'd1);
          end
        end
      end
      default: begin
        // normal mode, and the unused code
        mode_nxt = MODE_NORMAL;
        if (in_byte == CH_BSLASH) begin
          if (end_of_string) begin
            fail     = 1'b1;
            fail_err = ERR_TRAILING;
          end else begin
            mode_nxt = MODE_ESCAPE;
          end
        end else begin
          emit         = 1'b1;
          res.out_byte = in_byte;
        end
      end
    endcase

    // error result: zero byte, drop the rest of the string unless it ends here
    if (fail) begin
      emit           = 1'b1;
      res.out_byte   = '0;
      res.error_code = fail_err;
      mode_nxt       = end_of_string ? MODE_NORMAL : MODE_DISCARD;
      hex_acc_nxt    = '0;
    end
  end

endmodule

@@ sv/json_escape_decoder_core.sv @@
// JSON string escape decoder: one raw byte in, zero or one decoded byte out.
// Each byte is held in the input register; its result, if any, is then held
// in the result register. Throughput: one byte per cycle,
// sustained while the result side takes a transfer each cycle.
// Reset (synchronous, rst_n low) empties both registers and returns the decode
// mode to normal with a cleared hex value.
module json_escape_decoder_core (
  input  logic      clk,
  input  logic      rst_n,
  jed_in_if.sink    in_ch,
  jed_out_if.source out_ch
);
  import jed_pkg::*;

  // input register
  logic  in_valid_r;
  byte_t in_byte_r;
  logic  in_eos_r;

  // decode state
  mode_t mode_r;
  mode_t mode_nxt;
  byte_t hex_acc_r;
  byte_t hex_acc_nxt;

  // result register
  logic  out_valid_r;
  logic  out_valid_nxt;
  res_t  out_res_r;

  logic  emit;
  res_t  res;
  logic  out_free;
  logic  advance;
  logic  in_take;

  jed_step u_step (
    .mode          (mode_r),
    .hex_acc       (hex_acc_r),
    .in_byte       (in_byte_r),
    .end_of_string (in_eos_r),
    .mode_nxt      (mode_nxt),
    .hex_acc_nxt   (hex_acc_nxt),
    .emit          (emit),
    .res           (res)
  );

  assign out_free = !out_valid_r || out_ch.ready;
  // a byte that yields no result never waits on the result side
  assign advance  = in_valid_r && (!emit || out_free);
  assign in_take  = in_ch.valid && in_ch.ready;

  assign in_ch.ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_ch.in_byte;
      in_eos_r  <= in_ch.end_of_string;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_NORMAL;
      hex_acc_r <= '0;
    end else if (advance) begin
      mode_r    <= mode_nxt;
      hex_acc_r <= hex_acc_nxt;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_byte   = out_res_r.out_byte;
  assign out_ch.error_code = out_res_r.error_code;
  assign out_ch.last       = out_res_r.last;

endmodule
